### hdl/mandelbrot_escape_time_top_macros.svh
// Assertion macros for the Mandelbrot escape-time block.
`ifndef MANDELBROT_ESCAPE_TIME_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define MET_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/met_pkg.sv
// Shared types and constants of the Mandelbrot escape-time block.
`timescale 1ns / 1ps

package met_pkg;

	// Field widths
	localparam int C_W       = 32;
	localparam int LIMIT_W   = 16;
	localparam int BOUND_W   = 36;
	localparam int COUNT_W   = 17;
	localparam int CFG_IDX_W = 1;

	// Fraction bits of c and of the bound register
	localparam int IN_FRAC   = 28;

	// Digit width of the shared multiplier
	localparam int MUL_DIG_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND = 1'b1;

	// Register reset values
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd255;
	localparam logic [BOUND_W-1:0] BOUND_RST = 36'd1073741824;

	// Multiplier status
	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

### hdl/met_ifs.sv
// Handshake channel interfaces of the Mandelbrot escape-time block.
`timescale 1ns / 1ps

// Input point channel
interface met_in_if import met_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic signed [C_W-1:0] c_real;
	logic signed [C_W-1:0] c_imag;

	modport source (output valid, output c_real, output c_imag, input ready);
	modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

// Result channel
interface met_out_if import met_pkg::*;;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] iter_count;
	logic               in_set;

	modport source (output valid, output iter_count, output in_set, input ready);
	modport sink   (input valid, input iter_count, input in_set, output ready);
endinterface

// Register write channel
interface met_cfg_if import met_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BOUND_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/met_mul.sv
// Digit-serial unsigned multiplier shared by all products of one iteration.
`timescale 1ns / 1ps

module met_mul import met_pkg::*; #(
	parameter int MW = 34
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [MW-1:0]  a,
	input  logic [MW-1:0]  b,
	output logic [2*MW-1:0] prod,
	output mul_stat_t      stat
);

	localparam int DW   = MUL_DIG_W;
	localparam int ND   = (MW + DW - 1) / DW;
	localparam int DIGW = (ND > 1) ? $clog2(ND) : 1;
	localparam int PW   = 2 * MW;
	localparam int BPW  = ND * DW;

	logic            busy_q;
	logic            done_q;
	logic [DIGW-1:0] dig_q;
	logic [MW-1:0]   a_q;
	logic [BPW-1:0]  b_q;
	logic [PW-1:0]   acc_q;
	logic [DW-1:0]   digit;
	logic [MW+DW-1:0] pp;

	// Top digit of b first; acc shifts up one digit per step
	assign digit = b_q[BPW-1 -: DW];
	assign pp    = a_q * digit;

	// Step counter; done pulses the cycle after the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			dig_q  <= '0;
		end else begin
			done_q <= busy_q && (dig_q == '0);
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				dig_q  <= DIGW'(ND - 1);
			end else if (busy_q) begin
				dig_q <= dig_q - DIGW'(1);
				if (dig_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Operands and accumulator
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q   <= a;
			b_q   <= BPW'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= b_q << DW;
			acc_q <= (acc_q << DW) + PW'(pp);
		end
	end

	assign prod      = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### hdl/mandelbrot_escape_time_top.sv
// Mandelbrot escape-time unit: iterates z = z*z + c for one point at a time.
// Each iteration runs the three products xx, yy, xy in turn through the one
// 16-bit-digit multiplier, then the escape test and the update of z.
// One item at a time: a new point is accepted only in the idle state.
// arst_n clears the sequencer and output valid and loads limit 255 and bound 4.0.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_top_macros.svh"

module mandelbrot_escape_time_top import met_pkg::*; #(
	parameter int FRAC_BITS = 28
) (
	input  logic      clk,
	input  logic      arst_n,
	met_in_if.sink    src,
	met_out_if.source dst,
	met_cfg_if.sink   cfg
);

	localparam int MW   = FRAC_BITS + 6;                  // |x|, |y| up to 32.0
	localparam int PW   = 2 * MW;
	localparam int QW   = (FRAC_BITS + 12 > 64) ? 64 : FRAC_BITS + 12;
	localparam int DMW  = FRAC_BITS + 7;
	localparam int SW   = FRAC_BITS + 8;
	localparam int CMW  = FRAC_BITS + 4;
	localparam int CRW  = CMW + 1;
	localparam int SH_L = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
	localparam int SH_R = (FRAC_BITS >= IN_FRAC) ? 0 : IN_FRAC - FRAC_BITS;
	localparam int BW   = BOUND_W + SH_L;
	localparam int CMPW = (QW + 1 > BW) ? QW + 1 : BW;

	localparam logic [QW-1:0] DCAP = QW'(1) << (FRAC_BITS + 6);
	localparam logic [PW-1:0] PCAP = PW'(1) << (FRAC_BITS + 5);
	localparam logic signed [SW-1:0] LIM_P = $signed(SW'(1) << (FRAC_BITS + 5));
	localparam logic signed [SW-1:0] LIM_N = -LIM_P;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_KICK = 6'b000010,
		S_MUL  = 6'b000100,
		S_TEST = 6'b001000,
		S_UPD  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		OP_XX = 2'd0,
		OP_YY = 2'd1,
		OP_XY = 2'd2
	} op_t;

	state_t               state_q;
	op_t                  op_q;
	op_t                  nxt_op;
	logic [COUNT_W-1:0]   count_q;
	logic [COUNT_W-1:0]   lim_ext;
	logic [LIMIT_W-1:0]   limit_q;
	logic [BOUND_W-1:0]   bound_q;
	logic [MW-1:0]        xm_q, ym_q;
	logic                 xs_q, ys_q;
	logic signed [CRW-1:0] cr_q, ci_q;
	logic [QW-1:0]        xx_q, yy_q;
	logic [MW-1:0]        p_q;
	logic                 out_v_q;
	logic [COUNT_W-1:0]   out_cnt_q;
	logic                 out_set_q;

	logic                 mul_start;
	logic [MW-1:0]        mul_a, mul_b;
	logic [PW-1:0]        mul_prod;
	mul_stat_t            mul_stat;

	logic [CMW-1:0]       cr_mag, ci_mag;
	logic                 cr_neg, ci_neg;
	logic [PW-1:0]        full;
	logic [QW-1:0]        sq_res;
	logic [MW-1:0]        p_res;
	logic [QW-1:0]        dm_raw, dm_cap;
	logic [DMW-1:0]       tm;
	logic signed [SW-1:0] xsum, ysum;
	logic [MW:0]          x_sm, y_sm;
	logic [QW:0]          sq_sum;
	logic [BW-1:0]        bound_r;
	logic                 esc;

	// Magnitude of a Q3.28 value, moved to FRAC_BITS fraction bits (truncating)
	function automatic logic [CMW-1:0] c_mag(input logic [C_W-1:0] raw);
		logic [C_W-1:0]      m;
		logic [C_W+SH_L-1:0] w;
		m = raw[C_W-1] ? (C_W'(0) - raw) : raw;
		w = (C_W + SH_L)'(m) << SH_L;
		w = w >> SH_R;
		return w[CMW-1:0];
	endfunction

	// Sign and magnitude to two's complement
	function automatic logic signed [SW-1:0] sm_signed(input logic neg,
		input logic [DMW-1:0] mag);
		logic signed [SW-1:0] e;
		e = $signed(SW'(mag));
		return neg ? -e : e;
	endfunction

	// Clamp to +-32.0 and split into {sign, magnitude}
	function automatic logic [MW:0] to_sm(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] c;
		logic signed [SW-1:0] m;
		c = v;
		if (v > LIM_P) begin
			c = LIM_P;
		end else if (v < LIM_N) begin
			c = LIM_N;
		end
		m = c[SW-1] ? -c : c;
		return {c[SW-1], m[MW-1:0]};
	endfunction

	assign lim_ext = COUNT_W'(limit_q);

	// Point conversion at accept
	assign cr_neg = src.c_real[C_W-1];
	assign ci_neg = src.c_imag[C_W-1];
	assign cr_mag = c_mag(src.c_real);
	assign ci_mag = c_mag(src.c_imag);

	// Operation sequence: xx, yy, xy
	always_comb begin
		nxt_op = OP_XX;
		if (state_q == S_MUL) begin
			case (op_q)
				OP_XX:   nxt_op = OP_YY;
				OP_YY:   nxt_op = OP_XY;
				default: nxt_op = OP_XX;
			endcase
		end
	end

	// Multiplier operands
	always_comb begin
		case (nxt_op)
			OP_XX: begin
				mul_a = xm_q;
				mul_b = xm_q;
			end
			OP_YY: begin
				mul_a = ym_q;
				mul_b = ym_q;
			end
			default: begin
				mul_a = xm_q;
				mul_b = ym_q;
			end
		endcase
	end

	assign mul_start = (state_q == S_KICK) ||
		((state_q == S_MUL) && mul_stat.done && (op_q != OP_XY));

	met_mul #(
		.MW(MW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.prod  (mul_prod),
		.stat  (mul_stat)
	);

	// Product scaling: squares saturate at QW bits, xy at 32.0
	assign full   = mul_prod >> FRAC_BITS;
	assign sq_res = (full > PW'({QW{1'b1}})) ? {QW{1'b1}} : full[QW-1:0];
	assign p_res  = (full > PCAP) ? PCAP[MW-1:0] : full[MW-1:0];

	// Escape test; the unsaturated sum compares the same as the saturated one
	assign sq_sum  = (QW + 1)'(xx_q) + (QW + 1)'(yy_q);
	assign bound_r = BW'((BW'(bound_q) << SH_L) >> SH_R);
	assign esc     = CMPW'(sq_sum) > CMPW'(bound_r);

	// Next z
	assign dm_raw = (xx_q >= yy_q) ? (xx_q - yy_q) : (yy_q - xx_q);
	assign dm_cap = (dm_raw > DCAP) ? DCAP : dm_raw;
	assign tm     = {p_q, 1'b0};
	assign xsum   = sm_signed(xx_q < yy_q, dm_cap[DMW-1:0]) + SW'(cr_q);
	assign ysum   = sm_signed(xs_q ^ ys_q, tm) + SW'(ci_q);
	assign x_sm   = to_sm(xsum);
	assign y_sm   = to_sm(ysum);

	// Sequencer, registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_XX;
			count_q <= '0;
			out_v_q <= 1'b0;
			limit_q <= LIMIT_RST;
			bound_q <= BOUND_RST;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_LIMIT: limit_q <= cfg.data[LIMIT_W-1:0];
					REG_BOUND: bound_q <= cfg.data;
					default: ;
				endcase
			end
			// Output valid: set by a finished point, cleared once the beat is taken
			if ((state_q == S_DONE) && (!out_v_q || dst.ready)) begin
				out_v_q <= 1'b1;
			end else if (dst.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (src.valid) begin
						count_q <= COUNT_W'(1);
						state_q <= S_KICK;
					end
				end
				S_KICK: begin
					op_q    <= OP_XX;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mul_stat.done) begin
						if (op_q == OP_XY) begin
							state_q <= S_TEST;
						end else begin
							op_q <= nxt_op;
						end
					end
				end
				S_TEST: begin
					state_q <= esc ? S_DONE : S_UPD;
				end
				S_UPD: begin
					count_q <= count_q + COUNT_W'(1);
					state_q <= (count_q > lim_ext) ? S_DONE : S_KICK;
				end
				S_DONE: begin
					if (!out_v_q || dst.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (src.valid) begin
					cr_q <= cr_neg ? -$signed({1'b0, cr_mag}) : $signed({1'b0, cr_mag});
					ci_q <= ci_neg ? -$signed({1'b0, ci_mag}) : $signed({1'b0, ci_mag});
					xm_q <= MW'(cr_mag);
					ym_q <= MW'(ci_mag);
					xs_q <= cr_neg;
					ys_q <= ci_neg;
				end
			end
			S_MUL: begin
				if (mul_stat.done) begin
					case (op_q)
						OP_XX:   xx_q <= sq_res;
						OP_YY:   yy_q <= sq_res;
						default: p_q  <= p_res;
					endcase
				end
			end
			S_UPD: begin
				xs_q <= x_sm[MW];
				xm_q <= x_sm[MW-1:0];
				ys_q <= y_sm[MW];
				ym_q <= y_sm[MW-1:0];
			end
			S_DONE: begin
				if (!out_v_q || dst.ready) begin
					out_cnt_q <= count_q;
					out_set_q <= count_q > lim_ext;
				end
			end
			default: ;
		endcase
	end

	assign src.ready      = (state_q == S_IDLE);
	assign cfg.ready      = 1'b1;
	assign dst.valid      = out_v_q;
	assign dst.iter_count = out_cnt_q;
	assign dst.in_set     = out_set_q;

	// Checks
	`MET_ASSERT_NOW(a_idle_mul, src.ready, !mul_stat.busy, "input ready while multiplier busy")
	`MET_ASSERT_NOW(a_done_mul, mul_stat.done, state_q == S_MUL, "product done outside MUL")
	`MET_ASSERT_NOW(a_cnt_cap, state_q != S_IDLE, count_q <= lim_ext + COUNT_W'(2), "count past cap")
	`MET_ASSERT_NEXT(a_out_load, (state_q == S_DONE) && !out_v_q, out_v_q, "result not loaded")

endmodule

### tb/met_escape_check.sv
// Checker for the Mandelbrot escape-time unit: predicts each point's count and compares results.
`timescale 1ns / 1ps

module met_escape_check import met_pkg::*; #(
	parameter int FRAC_BITS = 28
) (
	input  logic        clk,
	input  logic        arst_n,
	met_in_if           pt_ch,
	met_out_if          res_ch,
	met_cfg_if          wr_ch,
	output int unsigned failures,
	output int unsigned outstanding
);

	localparam logic [63:0] CLAMP_MAG = 64'd1 << (FRAC_BITS + 5);
	localparam logic [63:0] DIFF_CAP  = 64'd1 << (FRAC_BITS + 6);
	localparam logic [63:0] ALL_ONES  = '1;

	typedef struct {
		logic signed [C_W-1:0] c_real;
		logic signed [C_W-1:0] c_imag;
		logic [COUNT_W-1:0]    iter_count;
		logic                  in_set;
	} escape_t;

	logic [LIMIT_W-1:0] limit_reg;
	logic [BOUND_W-1:0] bound_reg;
	escape_t            expected_q[$];
	escape_t            head;
	int unsigned        fail_cnt;
	int unsigned        result_idx;

	// (a*b) >> FRAC_BITS on the full product, saturated at cap
	function automatic logic [63:0] scaled_prod(logic [63:0] a, logic [63:0] b,
			logic [63:0] cap);
		logic [127:0] full;
		full = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
		if (full > {64'd0, cap})
			return cap;
		return full[63:0];
	endfunction

	// move a magnitude from IN_FRAC to FRAC_BITS fraction bits, truncating
	function automatic logic [63:0] to_frac(logic [63:0] m);
		if (FRAC_BITS >= IN_FRAC)
			return m << (FRAC_BITS - IN_FRAC);
		return m >> (IN_FRAC - FRAC_BITS);
	endfunction

	function automatic logic [63:0] magnitude(longint v);
		logic [63:0] m;
		m = v;
		if (v < 0)
			m = -m;
		return m;
	endfunction

	function automatic longint from_q328(logic signed [C_W-1:0] raw);
		longint      v;
		logic [63:0] s;
		v = raw;
		s = to_frac(magnitude(v));
		return (v < 0) ? -longint'(s) : longint'(s);
	endfunction

	function automatic longint clamp_z(longint v);
		if (v > longint'(CLAMP_MAG))
			return longint'(CLAMP_MAG);
		if (v < -longint'(CLAMP_MAG))
			return -longint'(CLAMP_MAG);
		return v;
	endfunction

	// run z = z*z + c until escape or the count cap
	function automatic escape_t predict_escape(logic signed [C_W-1:0] re,
			logic signed [C_W-1:0] im, logic [LIMIT_W-1:0] lim, logic [BOUND_W-1:0] bnd);
		longint      cr, ci, x, y, d, t;
		logic [63:0] ax, ay, xx, yy, dm, p, bound, sx, sy;
		logic [64:0] sum;
		int unsigned cnt, old;
		bit          done;
		escape_t     e;
		cr    = from_q328(re);
		ci    = from_q328(im);
		bound = to_frac({28'd0, bnd});
		x     = 0;
		y     = 0;
		cnt   = 0;
		done  = 0;
		while (!done) begin
			ax = magnitude(x);
			ay = magnitude(y);
			xx = scaled_prod(ax, ax, ALL_ONES);
			yy = scaled_prod(ay, ay, ALL_ONES);
			if (xx >= yy) begin
				dm = xx - yy;
				if (dm > DIFF_CAP)
					dm = DIFF_CAP;
				d = longint'(dm);
			end else begin
				dm = yy - xx;
				if (dm > DIFF_CAP)
					dm = DIFF_CAP;
				d = -longint'(dm);
			end
			// 2xy is twice the truncated product
			p = scaled_prod(ax, ay, CLAMP_MAG);
			t = longint'(p << 1);
			if ((x < 0) != (y < 0))
				t = -t;
			x = clamp_z(d + cr);
			y = clamp_z(t + ci);
			old = cnt;
			cnt++;
			// count cap is tested ahead of the bound
			sx  = scaled_prod(magnitude(x), magnitude(x), ALL_ONES);
			sy  = scaled_prod(magnitude(y), magnitude(y), ALL_ONES);
			sum = {1'b0, sx} + {1'b0, sy};
			if (sum[64])
				sum[63:0] = ALL_ONES;
			if (old > lim || sum[63:0] > bound)
				done = 1;
		end
		e.c_real     = re;
		e.c_imag     = im;
		e.iter_count = cnt[COUNT_W-1:0];
		e.in_set     = (cnt > lim);
		return e;
	endfunction

	task automatic report_mismatch(string msg);
		fail_cnt++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// track register writes, compare result beats, queue predictions for point beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_reg = LIMIT_RST;
			bound_reg = BOUND_RST;
			expected_q.delete();
			outstanding <= 0;
		end else begin
			if (wr_ch.valid && wr_ch.ready) begin
				case (wr_ch.index)
					REG_LIMIT: limit_reg = wr_ch.data[LIMIT_W-1:0];
					REG_BOUND: bound_reg = wr_ch.data;
					default: ;
				endcase
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result %0d with no point outstanding", result_idx));
				end else begin
					head = expected_q.pop_front();
					if (res_ch.iter_count !== head.iter_count)
						report_mismatch($sformatf("result %0d c=(%0d,%0d) iter_count %0d, want %0d",
							result_idx, head.c_real, head.c_imag, res_ch.iter_count,
							head.iter_count));
					if (res_ch.in_set !== head.in_set)
						report_mismatch($sformatf("result %0d c=(%0d,%0d) in_set %b, want %b",
							result_idx, head.c_real, head.c_imag, res_ch.in_set, head.in_set));
				end
				result_idx++;
			end
			if (pt_ch.valid && pt_ch.ready)
				expected_q.push_back(predict_escape(pt_ch.c_real, pt_ch.c_imag,
					limit_reg, bound_reg));
			outstanding <= expected_q.size();
		end
		failures <= fail_cnt;
	end

endmodule

### tb/mandelbrot_escape_time_top_tb.sv
// Testbench top for the Mandelbrot escape-time unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module mandelbrot_escape_time_top_tb;
	import met_pkg::*;

	localparam int FRAC_BITS     = 28;
	localparam int RANDOM_POINTS = 1250;
	localparam int HOLD_CYCLES   = 100;

	// Q3.28 constants
	localparam logic signed [C_W-1:0] ONE     = 32'sh1000_0000;
	localparam logic signed [C_W-1:0] TWO     = 32'sh2000_0000;
	localparam logic signed [C_W-1:0] QUARTER = 32'sh0400_0000;
	localparam logic signed [C_W-1:0] C_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [C_W-1:0] C_MIN   = 32'sh8000_0000;
	localparam int unsigned RE_SPAN = 697932185;  // -2.0 .. 0.6
	localparam int unsigned IM_HALF = 335544320;  // 1.25

	logic        clk;
	logic        arst_n;
	int unsigned esc_failures;
	int unsigned esc_outstanding;
	bit          steady_src;
	bit          steady_dst;
	int unsigned random_sent;
	int unsigned batch_len;
	int unsigned r;
	logic [LIMIT_W-1:0] lim;
	logic [BOUND_W-1:0] bnd;
	logic signed [C_W-1:0] re, im;

	met_in_if  pt_ch ();
	met_out_if res_ch ();
	met_cfg_if wr_ch ();

	mandelbrot_escape_time_top #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (pt_ch),
		.dst    (res_ch),
		.cfg    (wr_ch)
	);

	met_escape_check #(.FRAC_BITS(FRAC_BITS)) esc_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.pt_ch       (pt_ch),
		.res_ch      (res_ch),
		.wr_ch       (wr_ch),
		.failures    (esc_failures),
		.outstanding (esc_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned g;
		g = $urandom_range(0, 99);
		if (g < 55)
			return 0;
		if (g < 85)
			return $urandom_range(1, 3);
		if (g < 97)
			return $urandom_range(4, 16);
		return $urandom_range(30, 150);
	endfunction

	function automatic logic signed [C_W-1:0] corner_value();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return C_MAX;
			2: return C_MIN;
			3: return 1;
			4: return -1;
			5: return TWO;
			6: return -TWO;
			default: return QUARTER;
		endcase
	endfunction

	// one point beat, with an optional idle gap ahead of it
	task automatic send_point(input logic signed [C_W-1:0] c_re,
			input logic signed [C_W-1:0] c_im);
		int unsigned gap;
		gap = steady_src ? 0 : pick_gap();
		if (gap != 0) begin
			pt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt_ch.valid  <= 1'b1;
		pt_ch.c_real <= c_re;
		pt_ch.c_imag <= c_im;
		do @(posedge clk); while (!pt_ch.ready);
	endtask

	// stop sending and wait until every result has come back
	task automatic drain();
		pt_ch.valid <= 1'b0;
		do @(posedge clk); while (esc_outstanding != 0);
	endtask

	// valid is left high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] val);
		wr_ch.valid <= 1'b1;
		wr_ch.index <= idx;
		wr_ch.data  <= val;
		do @(posedge clk); while (!wr_ch.ready);
	endtask

	// both registers, random order; junk above the limit field
	task automatic configure(input logic [LIMIT_W-1:0] new_lim, input logic [BOUND_W-1:0] new_bnd);
		logic [BOUND_W-1:0] lim_word;
		lim_word = {20'($urandom), new_lim};
		if ($urandom_range(0, 1)) begin
			write_reg(REG_LIMIT, lim_word);
			write_reg(REG_BOUND, new_bnd);
		end else begin
			write_reg(REG_BOUND, new_bnd);
			write_reg(REG_LIMIT, lim_word);
		end
		wr_ch.valid <= 1'b0;
	endtask

	// result side ready: random runs high and low, sometimes none low
	initial begin
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			res_ch.ready <= 1'b1;
			repeat (steady_dst ? 1 : $urandom_range(1, 12)) @(posedge clk);
			if (!steady_dst && $urandom_range(0, 2) == 0) begin
				res_ch.ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	// stimulus
	initial begin
		arst_n       <= 1'b0;
		pt_ch.valid  <= 1'b0;
		pt_ch.c_real <= '0;
		pt_ch.c_imag <= '0;
		wr_ch.valid  <= 1'b0;
		wr_ch.index  <= REG_LIMIT;
		wr_ch.data   <= '0;
		steady_src   = 1'b0;
		steady_dst   = 1'b0;
		random_sent  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: limit 255, bound 4.0
		send_point(0, 0);
		send_point(C_MAX, 0);
		send_point(C_MIN, C_MIN);
		send_point(0, C_MAX);
		send_point(-TWO, 0);
		send_point(QUARTER, 0);
		send_point(-(3 * QUARTER), ONE / 10);
		send_point(0, ONE);
		send_point(C_MIN, C_MAX);
		send_point(1, -1);
		drain();

		// limit of zero: count is 1 or 2
		configure(0, BOUND_RST);
		send_point(0, 0);
		send_point(3 * ONE, 0);
		send_point(-ONE, 0);
		drain();

		// largest limit and bound; these points clamp and escape fast
		configure(16'hFFFF, '1);
		send_point(C_MAX, 0);
		send_point(C_MIN, 0);
		send_point(C_MIN, C_MAX);
		send_point(3 * ONE, 3 * ONE);
		drain();

		// zero bound: a point at the origin or with tiny squares never escapes
		configure(20, 0);
		send_point(0, 0);
		send_point(1, 0);
		send_point(ONE / 2, ONE / 2);
		drain();

		// random batches, each under its own settings
		while (random_sent < RANDOM_POINTS) begin
			r = $urandom_range(0, 99);
			if (r < 75)
				lim = LIMIT_W'($urandom_range(0, 40));
			else if (r < 95)
				lim = LIMIT_W'($urandom_range(41, 120));
			else
				lim = LIMIT_W'($urandom_range(200, 300));
			r = $urandom_range(0, 99);
			if (r < 50)
				bnd = BOUND_RST;
			else if (r < 65)
				bnd = {4'($urandom), 32'($urandom)};
			else if (r < 78)
				bnd = BOUND_W'($urandom_range(0, 1 << 30));
			else if (r < 90)
				bnd = '1;
			else
				bnd = '0;
			configure(lim, bnd);
			steady_src = ($urandom_range(0, 4) == 0);
			steady_dst = ($urandom_range(0, 4) == 0);
			batch_len  = $urandom_range(15, 60);
			repeat (batch_len) begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					// interesting region around the set
					re = int'($urandom_range(0, RE_SPAN)) - int'(TWO);
					im = int'($urandom_range(0, 2 * IM_HALF)) - int'(IM_HALF);
				end else if (r < 85) begin
					re = $urandom;
					im = $urandom;
				end else begin
					re = corner_value();
					im = corner_value();
				end
				send_point(re, im);
				random_sent++;
				if ($urandom_range(0, 60) == 0)
					drain();
			end
			drain();
		end

		steady_dst = 1'b0;
		drain();
		repeat (HOLD_CYCLES) @(posedge clk);
		if (esc_failures == 0 && esc_outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#200000000;
		$display("simulation failed");
		$finish;
	end

endmodule
